// ===== design/acmr_pkg.sv =====
`timescale 1ns / 1ps

package acmr_pkg;

  localparam int NumStates  = 256;
  localparam int Alphabet   = 256;
  localparam int ByteW      = 8;
  localparam int StateW     = $clog2(NumStates);
  localparam int GotoAddrW  = StateW + ByteW;
  localparam int GotoDepth  = NumStates * Alphabet;
  localparam int HopW       = $clog2(NumStates + 1);
  localparam int RecordW    = 8;
  localparam int LenW       = 7;
  localparam int RetractW   = 6;
  localparam int MaxWordLen = 64;

  localparam logic [HopW-1:0]     HopLimit   = HopW'(NumStates);
  localparam logic [LenW-1:0]     LenClamp   = LenW'(MaxWordLen);
  localparam logic [LenW-1:0]     RetractSat = LenW'((1 << RetractW) - 1);

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_GOTO = 2'd1,
    KIND_INFO = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_EV    = 5'b01000,
    S_MEV   = 5'b10000
  } fsm_e;

  // One entry of the per-state memory: failure link and match record.
  typedef struct packed {
    logic [StateW-1:0]  fail;
    logic               mvalid;
    logic [RecordW-1:0] record;
    logic [LenW-1:0]    len;
    logic               accept;
  } info_t;

endpackage

// ===== design/aho_corasick_match_replace_top.sv =====
`timescale 1ns / 1ps

// Streaming multi-pattern matcher with match replacement. Software loads the
// automaton through the input channel. A goto-edge write (kind 1) or a
// state-info write (kind 2) gives no result. A text byte (kind 0) gives
// exactly one result. Its walk reads the goto memory and the failure-link
// memory, then evaluates the data; on a miss away from the root it hops along
// the failure link, and each hop is again one read followed by one evaluation.
// If the failure links loop, the walk gives up after 256 hops and tries the
// root edge once more. A result waits in an output register, so the next
// item is taken while the result is still on offer. If that register is
// still full when the next result is ready, the walk holds in its final state
// until the earlier result has been transferred. After reset the goto memory,
// 65536 entries deep, is cleared one entry per cycle. During that clearing
// pass no input transfer is taken, although configuration writes are. Failure
// links read from a state whose info was never written are undefined.
module aho_corasick_match_replace_top import acmr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_restart_on_hit_i,
  // input item channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic                first_of_text_i,
  input  logic [ByteW-1:0]    text_byte_i,
  input  logic [StateW-1:0]   state_index_i,
  input  logic [StateW-1:0]   next_state_i,
  input  logic [StateW-1:0]   fail_state_i,
  input  logic                match_valid_i,
  input  logic [RecordW-1:0]  record_id_i,
  input  logic [LenW-1:0]     pattern_len_i,
  input  logic                accept_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_byte_o,
  output logic                copy_byte_o,
  output logic                replaced_o,
  output logic [RecordW-1:0]  match_record_o,
  output logic [RetractW-1:0] retract_count_o
);

  // Control state.
  fsm_e                 state_q, state_d;
  logic                 rom_q;
  logic [GotoAddrW-1:0] clr_cnt_q;
  logic [StateW-1:0]    cur_q, cur_d;
  logic [StateW-1:0]    st_q, st_d;
  logic [StateW-1:0]    fin_q, fin_d;
  logic [HopW-1:0]      hop_q, hop_d;
  logic [NumStates-1:0] written_q;
  logic                 out_valid_q, out_valid_d;

  // Payload registers.
  logic [ByteW-1:0]     byte_q;
  logic [ByteW-1:0]     out_byte_q;
  logic                 copy_q, repl_q;
  logic [RecordW-1:0]   rec_q;
  logic [RetractW-1:0]  retract_q;

  // Memories.
  logic [StateW-1:0]    goto_mem [GotoDepth];
  info_t                info_mem [NumStates];
  logic [StateW-1:0]    goto_rdata_q;
  info_t                info_rdata_q;

  logic                 goto_we;
  logic [GotoAddrW-1:0] goto_waddr;
  logic [StateW-1:0]    goto_wdata;
  logic [GotoAddrW-1:0] goto_raddr;
  logic                 info_we;
  info_t                info_wdata;
  logic [StateW-1:0]    info_raddr;

  logic                 in_xfer;
  logic                 slot_free;
  logic                 mev_done;
  logic                 hit;
  logic [LenW-1:0]      len_clamped;
  logic [LenW-1:0]      len_minus;
  logic [RetractW-1:0]  retract_val;

  // The configuration register may be written at any time.
  assign cfg_ready_o = 1'b1;

  // Items are only taken in idle: the walk for one text byte owns both memories.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;

  // The output register is free when empty or when its result is leaving now.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign mev_done   = (state_q == S_MEV) && slot_free;

  // Write ports. During the clearing pass the goto memory is swept with zeros;
  // afterwards it is written by goto-edge transfers only.
  always_comb begin
    goto_we    = 1'b0;
    goto_waddr = {state_index_i, text_byte_i};
    goto_wdata = next_state_i;
    info_we    = 1'b0;
    if (state_q == S_CLEAR) begin
      goto_we    = 1'b1;
      goto_waddr = clr_cnt_q;
      goto_wdata = '0;
    end else if (in_xfer) begin
      unique case (kind_e'(kind_i))
        KIND_GOTO: goto_we = 1'b1;
        KIND_INFO: info_we = 1'b1;
        default:   ;
      endcase
    end
  end

  always_comb begin
    info_wdata.fail   = fail_state_i;
    info_wdata.mvalid = match_valid_i;
    info_wdata.record = record_id_i;
    info_wdata.len    = pattern_len_i;
    info_wdata.accept = accept_i;
  end

  // Read ports. The goto lookup and the failure link of the current walk state
  // are fetched together; once the walk ends, the info port is pointed at the
  // reached state so that its match record is ready in the following cycle.
  assign goto_raddr = {st_q, byte_q};

  always_comb begin
    unique case (state_q)
      S_EV:    info_raddr = fin_d;
      S_MEV:   info_raddr = fin_q;
      default: info_raddr = st_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) begin
      goto_mem[goto_waddr] <= goto_wdata;
    end
    goto_rdata_q <= goto_mem[goto_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[state_index_i] <= info_wdata;
    end
    info_rdata_q <= info_mem[info_raddr];
  end

  // A match record counts only once its state has been written; before that
  // the state reads as carrying no match.
  assign hit = written_q[fin_q] && info_rdata_q.mvalid;

  // Retraction: the word length is clamped to the longest word, reduced by
  // one, and saturated to the width of the result field.
  always_comb begin
    len_clamped = (info_rdata_q.len > LenClamp) ? LenClamp : info_rdata_q.len;
    len_minus   = (len_clamped == '0) ? '0 : len_clamped - LenW'(1);
    retract_val = (len_minus > RetractSat) ? RetractSat[RetractW-1:0]
                                           : len_minus[RetractW-1:0];
  end

  // Sequencer for one text byte: read, evaluate, and either hop along the
  // failure link or finish with the match record of the reached state.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    st_d        = st_q;
    fin_d       = fin_q;
    hop_d       = hop_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer && (kind_e'(kind_i) == KIND_TEXT)) begin
          st_d    = first_of_text_i ? '0 : cur_q;
          hop_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        // An edge ends the walk, and so does a miss at the root, whose
        // target then reads as zero.
        fin_d = goto_rdata_q;
        if ((goto_rdata_q != '0) || (st_q == '0)) begin
          state_d = S_MEV;
        end else if (hop_q == HopLimit) begin
          // The failure links loop: restart at the root and try its edge once.
          st_d    = '0;
          state_d = S_RD;
        end else begin
          st_d    = info_rdata_q.fail;
          hop_d   = hop_q + HopW'(1);
          state_d = S_RD;
        end
      end
      S_MEV: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          cur_d       = (hit && (info_rdata_q.accept || rom_q)) ? '0 : fin_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rom_q       <= 1'b1;
      clr_cnt_q   <= '0;
      cur_q       <= '0;
      st_q        <= '0;
      fin_q       <= '0;
      hop_q       <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      st_q        <= st_d;
      fin_q       <= fin_d;
      hop_q       <= hop_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rom_q <= cfg_restart_on_hit_i;
      end
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + GotoAddrW'(1);
      end
      if (info_we) begin
        written_q[state_index_i] <= 1'b1;
      end
    end
  end

  // Payload: the text byte is held for the walk, the result for the output.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= text_byte_i;
    end
    if (mev_done) begin
      out_byte_q <= byte_q;
      if (hit && info_rdata_q.accept) begin
        copy_q    <= 1'b0;
        repl_q    <= 1'b1;
        rec_q     <= info_rdata_q.record;
        retract_q <= retract_val;
      end else begin
        copy_q    <= 1'b1;
        repl_q    <= 1'b0;
        rec_q     <= '0;
        retract_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign copy_byte_o     = copy_q;
  assign replaced_o      = repl_q;
  assign match_record_o  = rec_q;
  assign retract_count_o = retract_q;

  // A result is either copied or replaced, never both and never neither.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (copy_byte_o != replaced_o))
    else $error("result is neither strictly copied nor strictly replaced");

  // The hop counter never runs past the failure-link cycle limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hop_q <= HopLimit)
    else $error("failure-link hop counter overran its limit");

  // A replaced match always sends the automaton back to the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mev_done && hit && info_rdata_q.accept) |=> (cur_q == '0) && replaced_o)
    else $error("accepted match did not return to the root");

  // No input transfer is taken while the goto memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("input ready during the clearing pass");

endmodule
